>>> hdl/sics_pkg.sv
// Shared types and character codes for the source input completeness scanner.
// No dependencies; imported by sics_scan and source_input_completeness_scanner.

package sics_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_W           = 16;
    localparam int CH_W            = 8;
    localparam int TDATA_OUT_W     = 72;

    localparam logic [CH_W-1:0] CH_NL        = 8'h0A;
    localparam logic [CH_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [CH_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [CH_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [CH_W-1:0] CH_DASH      = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [CH_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE    = 8'h7D;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STRING,
        MODE_TRIPLE
    } mode_t;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_DASH,
        PEND_SLASH,
        PEND_STAR,
        PEND_Q1,
        PEND_Q2
    } pend_t;

    typedef struct packed {
        logic             in_long_string;
        logic [OUT_W-1:0] comment_nesting;
        logic [OUT_W-1:0] bracket_count;
        logic [OUT_W-1:0] paren_count;
        logic [OUT_W-1:0] brace_count;
        logic             complete;
    } result_t;

endpackage

>>> hdl/sics_scan.sv
// Scanner state registers and the per-byte update logic (modes, pending
// characters, saturating counts). Produces the verdict on the final byte.
// Depends on sics_pkg.

module sics_scan #(
    parameter int COUNT_WIDTH = sics_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [sics_pkg::CH_W-1:0]    ch,
    input  logic                         last,
    output sics_pkg::result_t            result
);
    import sics_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] SMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] SMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic [COUNT_WIDTH-1:0] UMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] ZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] ONE  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    mode_t                  mode_reg, mode_next;
    pend_t                  pend_reg, pend_next;
    logic                   escape_reg, escape_next;
    logic [COUNT_WIDTH-1:0] brace_reg, brace_next;
    logic [COUNT_WIDTH-1:0] paren_reg, paren_next;
    logic [COUNT_WIDTH-1:0] bracket_reg, bracket_next;
    logic [COUNT_WIDTH-1:0] depth_reg, depth_next;

    logic                   brace_up, brace_dn, paren_up, paren_dn;
    logic                   bracket_up, bracket_dn, depth_up, depth_dn;

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        escape_next = escape_reg;
        brace_up    = 1'b0;
        brace_dn    = 1'b0;
        paren_up    = 1'b0;
        paren_dn    = 1'b0;
        bracket_up  = 1'b0;
        bracket_dn  = 1'b0;
        depth_up    = 1'b0;
        depth_dn    = 1'b0;

        unique case (mode_reg)
            MODE_LINE:
            begin
                if (ch == CH_NL)
                    mode_next = MODE_NORMAL;
            end
            MODE_BLOCK:
            begin
                pend_next = PEND_NONE;
                if (pend_reg == PEND_SLASH && ch == CH_STAR)
                    depth_up = 1'b1;
                else if (pend_reg == PEND_STAR && ch == CH_SLASH)
                begin
                    depth_dn = 1'b1;
                    // depth reaches zero after this close
                    if (depth_reg[COUNT_WIDTH-1:1] == '0)
                        mode_next = MODE_NORMAL;
                end
                else if (ch == CH_SLASH)
                    pend_next = PEND_SLASH;
                else if (ch == CH_STAR)
                    pend_next = PEND_STAR;
            end
            MODE_STRING:
            begin
                if (escape_reg)
                    escape_next = 1'b0;
                else if (ch == CH_BACKSLASH)
                    escape_next = 1'b1;
                else if (ch == CH_QUOTE || ch == CH_NL)
                    mode_next = MODE_NORMAL;
            end
            MODE_TRIPLE:
            begin
                if (ch != CH_QUOTE)
                    pend_next = PEND_NONE;
                else if (pend_reg == PEND_Q2)
                begin
                    pend_next = PEND_NONE;
                    mode_next = MODE_NORMAL;
                end
                else if (pend_reg == PEND_Q1)
                    pend_next = PEND_Q2;
                else
                    pend_next = PEND_Q1;
            end
            default:
            begin
                // normal code
                mode_next = MODE_NORMAL;
                pend_next = PEND_NONE;
                if (pend_reg == PEND_DASH && ch == CH_DASH)
                    mode_next = MODE_LINE;
                else if (pend_reg == PEND_SLASH && ch == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                    depth_up  = 1'b1;
                end
                else if (pend_reg == PEND_Q1)
                begin
                    if (ch == CH_QUOTE)
                        pend_next = PEND_Q2;
                    else
                    begin
                        // one quote then other text: plain string, this byte inside it
                        mode_next = MODE_STRING;
                        if (ch == CH_BACKSLASH)
                            escape_next = 1'b1;
                        else if (ch == CH_NL)
                            mode_next = MODE_NORMAL;
                    end
                end
                else if (pend_reg == PEND_Q2 && ch == CH_QUOTE)
                    mode_next = MODE_TRIPLE;
                else
                begin
                    case (ch)
                        CH_QUOTE:    pend_next  = PEND_Q1;
                        CH_DASH:     pend_next  = PEND_DASH;
                        CH_SLASH:    pend_next  = PEND_SLASH;
                        CH_LBRACE:   brace_up   = 1'b1;
                        CH_RBRACE:   brace_dn   = 1'b1;
                        CH_LPAREN:   paren_up   = 1'b1;
                        CH_RPAREN:   paren_dn   = 1'b1;
                        CH_LBRACKET: bracket_up = 1'b1;
                        CH_RBRACKET: bracket_dn = 1'b1;
                        default:     ;
                    endcase
                end
            end
        endcase

        brace_next = brace_reg;
        if (brace_up && brace_reg != SMAX)
            brace_next = brace_reg + ONE;
        else if (brace_dn && brace_reg != SMIN)
            brace_next = brace_reg - ONE;

        paren_next = paren_reg;
        if (paren_up && paren_reg != SMAX)
            paren_next = paren_reg + ONE;
        else if (paren_dn && paren_reg != SMIN)
            paren_next = paren_reg - ONE;

        bracket_next = bracket_reg;
        if (bracket_up && bracket_reg != SMAX)
            bracket_next = bracket_reg + ONE;
        else if (bracket_dn && bracket_reg != SMIN)
            bracket_next = bracket_reg - ONE;

        depth_next = depth_reg;
        if (depth_up && depth_reg != UMAX)
            depth_next = depth_reg + ONE;
        else if (depth_dn && depth_reg != ZERO)
            depth_next = depth_reg - ONE;
    end

    // verdict from the updated state; a held character does not count
    always_comb
    begin
        result.complete = (brace_next[COUNT_WIDTH-1] || brace_next == ZERO)
                       && (paren_next[COUNT_WIDTH-1] || paren_next == ZERO)
                       && (bracket_next[COUNT_WIDTH-1] || bracket_next == ZERO)
                       && depth_next == ZERO
                       && mode_next != MODE_TRIPLE;
        result.brace_count     = OUT_W'(signed'(brace_next));
        result.paren_count     = OUT_W'(signed'(paren_next));
        result.bracket_count   = OUT_W'(signed'(bracket_next));
        result.comment_nesting = OUT_W'(depth_next);
        result.in_long_string  = (mode_next == MODE_TRIPLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            pend_reg    <= PEND_NONE;
            escape_reg  <= 1'b0;
            brace_reg   <= '0;
            paren_reg   <= '0;
            bracket_reg <= '0;
            depth_reg   <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                // end of text: back to the reset state
                mode_reg    <= MODE_NORMAL;
                pend_reg    <= PEND_NONE;
                escape_reg  <= 1'b0;
                brace_reg   <= '0;
                paren_reg   <= '0;
                bracket_reg <= '0;
                depth_reg   <= '0;
            end
            else
            begin
                mode_reg    <= mode_next;
                pend_reg    <= pend_next;
                escape_reg  <= escape_next;
                brace_reg   <= brace_next;
                paren_reg   <= paren_next;
                bracket_reg <= bracket_next;
                depth_reg   <= depth_next;
            end
        end
    end

    a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> mode_reg == MODE_STRING)
        else $error("escape flag set outside a plain string");

    a_block_pending: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_BLOCK |->
            (pend_reg == PEND_NONE || pend_reg == PEND_SLASH || pend_reg == PEND_STAR))
        else $error("quote or dash held inside a block comment");

    a_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_LINE || mode_reg == MODE_STRING) |-> pend_reg == PEND_NONE)
        else $error("character held in line comment or plain string");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> mode_reg == MODE_NORMAL && pend_reg == PEND_NONE
                         && depth_reg == ZERO && brace_reg == ZERO)
        else $error("state not cleared after final byte");

endmodule

>>> hdl/source_input_completeness_scanner.sv
// Top level of the source input completeness scanner: input register, scanner,
// result register with stream handshakes on both sides.
// Depends on sics_pkg and sics_scan.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata = ch, tlast = last
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata = verdict and counts
//
// One byte a cycle while no final byte waits; each byte is held in the input
// register; a final byte's verdict enters the result register as it leaves.
// The per-byte mode and counter update is the only logic between the two.
// Reset clears the mode, pending character and all counts.
// Ordinary bytes never stall; a final byte waits in the input register only
// while an earlier verdict has not been taken.

module source_input_completeness_scanner #(
    parameter int COUNT_WIDTH = sics_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sics_pkg::CH_W-1:0]         s_axis_tdata,   // [7:0] ch
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] complete, [16:1] brace_count, [32:17] paren_count,
    // [48:33] bracket_count, [64:49] comment_nesting, [65] in_long_string
    output logic [sics_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);
    import sics_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CH_W-1:0]   ch_reg;
    logic              last_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg;
    result_t           scan_result;
    logic              advance;
    logic              s_take;

    // a non-final byte moves on regardless of the output side
    assign advance       = in_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (advance && last_reg)
            result_reg <= scan_result;
    end

    sics_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (ch_reg),
        .last   (last_reg),
        .result (scan_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_OUT_W'(result_reg);

endmodule
